FILE: rtl/core/rqsd_pkg.sv
package rqsd_pkg;

    localparam int TIME_WIDTH     = 32;
    localparam int DEBOUNCE_WIDTH = 16;
    localparam int STEP_WIDTH     = 16;
    localparam int PHASE_WIDTH    = 3;

    localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    localparam logic [PHASE_WIDTH-1:0] PH_WAIT   = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_STARTL = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_STARTR = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_TURNL  = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_TURNR  = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_FINL   = 3'd5;
    localparam logic [PHASE_WIDTH-1:0] PH_FINR   = 3'd6;

    typedef struct packed {
        logic                  operation;
        logic                  line_a;
        logic                  line_b;
        logic [TIME_WIDTH-1:0] time_ms;
    } item_t;

    typedef struct packed {
        logic                  has_result;
        logic [STEP_WIDTH-1:0] left_steps;
        logic [STEP_WIDTH-1:0] right_steps;
    } report_t;

endpackage

FILE: rtl/core/rotary_quadrature_step_decoder_core.sv
// rotary encoder step decoder
// s_axis carries one transaction per line sample or poll request:
//   tuser is the operation (0 = line sample, 1 = poll and clear),
//   tdata holds line_a, line_b and the millisecond timestamp.
// m_axis carries one transaction per poll that finds input detected since
// the last report: the left and right detent step counts.
// cfg carries the debounce time in ms; it is always ready and should only be
// written while no transaction is in flight.
// each transaction is held in the input register, where the state
// machine and counters update; a report lands in the output register and
// leaves from there to m_axis. one transaction per cycle is sustained
// unless a report is blocked behind a stalled m_axis.
// a stalled m_axis holds its report; samples keep flowing until a second
// report is waiting, then s_tready drops until the first one is taken.
// reset returns the machine to waiting, clears counts, detected flag and
// event time, and loads a debounce time of 50 ms.
module rotary_quadrature_step_decoder_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // line_a, line_b, time_ms[31:0], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_steps[15:0], right_steps[15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import rqsd_pkg::*;

    logic                      in_valid_reg;
    item_t                     in_item_reg;
    logic                      out_valid_reg;
    logic [2*STEP_WIDTH-1:0]   out_data_reg;
    logic [DEBOUNCE_WIDTH-1:0] debounce_reg;

    report_t                   report;
    logic                      out_free;
    logic                      advance;

    assign out_free  = ~out_valid_reg | m_tready;
    assign advance   = in_valid_reg & (~report.has_result | out_free);
    assign s_tready  = ~in_valid_reg | advance;
    assign cfg_ready = 1'b1;

    rqsd_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (in_item_reg),
        .commit     (advance),
        .debounce_ms(debounce_reg),
        .report     (report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.operation <= s_tuser;
            in_item_reg.line_a    <= s_tdata[0];
            in_item_reg.line_b    <= s_tdata[1];
            in_item_reg.time_ms   <= s_tdata[33:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance & report.has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && report.has_result)
        begin
            out_data_reg <= {report.right_steps, report.left_steps};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debounce_reg <= cfg_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/rqsd_step.sv
module rqsd_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rqsd_pkg::item_t                     item,
    input  logic                                commit,
    input  logic [rqsd_pkg::DEBOUNCE_WIDTH-1:0] debounce_ms,
    output rqsd_pkg::report_t                   report
);
    import rqsd_pkg::*;

    logic [PHASE_WIDTH-1:0] phase_reg;
    logic [PHASE_WIDTH-1:0] phase_next;
    logic [COUNT_WIDTH-1:0] left_reg;
    logic [COUNT_WIDTH-1:0] left_next;
    logic [COUNT_WIDTH-1:0] right_reg;
    logic [COUNT_WIDTH-1:0] right_next;
    logic                   detected_reg;
    logic                   detected_next;
    logic [TIME_WIDTH-1:0]  last_event_reg;
    logic [TIME_WIDTH-1:0]  last_event_next;

    logic                   both_hi;
    logic                   both_lo;
    logic                   a_hi_b_lo;
    logic                   a_lo_b_hi;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   push_long;

    assign both_hi   = item.line_a & item.line_b;
    assign both_lo   = ~item.line_a & ~item.line_b;
    assign a_hi_b_lo = item.line_a & ~item.line_b;
    assign a_lo_b_hi = ~item.line_a & item.line_b;
    assign elapsed   = item.time_ms - last_event_reg;
    assign push_long = elapsed > {{(TIME_WIDTH-DEBOUNCE_WIDTH){1'b0}}, debounce_ms};

    always_comb
    begin
        phase_next      = phase_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        detected_next   = detected_reg;
        last_event_next = last_event_reg;
        if (item.operation == OP_POLL)
        begin
            if (detected_reg)
            begin
                left_next     = '0;
                right_next    = '0;
                detected_next = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_STARTL:
                begin
                    if (both_hi)
                    begin
                        phase_next = PH_WAIT;
                        if (push_long)
                        begin
                            detected_next = 1'b1;
                        end
                    end
                    else if (both_lo)
                    begin
                        phase_next = PH_TURNL;
                    end
                end
                PH_STARTR:
                begin
                    if (both_hi)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else if (both_lo)
                    begin
                        phase_next = PH_TURNR;
                    end
                end
                PH_TURNL:
                begin
                    if (a_lo_b_hi)
                    begin
                        phase_next = PH_STARTL;
                    end
                    else if (a_hi_b_lo)
                    begin
                        phase_next = PH_FINL;
                    end
                end
                PH_TURNR:
                begin
                    if (a_hi_b_lo)
                    begin
                        phase_next = PH_STARTR;
                    end
                    else if (a_lo_b_hi)
                    begin
                        phase_next = PH_FINR;
                    end
                end
                PH_FINL:
                begin
                    if (both_lo)
                    begin
                        phase_next = PH_TURNL;
                    end
                    else if (both_hi)
                    begin
                        phase_next      = PH_WAIT;
                        right_next      = '0;
                        left_next       = left_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                        detected_next   = 1'b1;
                        last_event_next = item.time_ms;
                    end
                end
                PH_FINR:
                begin
                    if (both_lo)
                    begin
                        phase_next = PH_TURNR;
                    end
                    else if (both_hi)
                    begin
                        phase_next      = PH_WAIT;
                        left_next       = '0;
                        right_next      = right_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                        detected_next   = 1'b1;
                        last_event_next = item.time_ms;
                    end
                end
                default:
                begin
                    if (a_hi_b_lo)
                    begin
                        phase_next = PH_STARTR;
                    end
                    else if (a_lo_b_hi)
                    begin
                        phase_next      = PH_STARTL;
                        last_event_next = item.time_ms;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            left_reg       <= '0;
            right_reg      <= '0;
            detected_reg   <= 1'b0;
            last_event_reg <= '0;
        end
        else if (commit)
        begin
            phase_reg      <= phase_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            detected_reg   <= detected_next;
            last_event_reg <= last_event_next;
        end
    end

    assign report.has_result = (item.operation == OP_POLL) & detected_reg;

    generate
        if (COUNT_WIDTH >= STEP_WIDTH)
        begin : g_trunc
            assign report.left_steps  = left_reg[STEP_WIDTH-1:0];
            assign report.right_steps = right_reg[STEP_WIDTH-1:0];
        end
        else
        begin : g_extend
            assign report.left_steps  = {{(STEP_WIDTH-COUNT_WIDTH){1'b0}}, left_reg};
            assign report.right_steps = {{(STEP_WIDTH-COUNT_WIDTH){1'b0}}, right_reg};
        end
    endgenerate

endmodule
